// ===== sv/ddo_pkg.sv =====
// Shared types, constants and tables for the differential-drive odometry block.
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 20;
  localparam int COUNT_BITS_DEF   = 32;

  localparam int ANGLE_W    = 32;
  localparam int TRIG_W     = 33;
  localparam int ATAN_IDX_W = 5;
  localparam int MUL_A_W    = 21;
  localparam int MUL_B_W    = 23;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN  = 33'sd652032874;
  localparam logic signed [TRIG_W-1:0] QUARTER_TURN = 33'sd1073741824;
  localparam logic signed [TRIG_W-1:0] HALF_TURN    = 33'sd2147483648;

  localparam logic [15:0] DELTA_MAX = 16'd32767;

  localparam logic [1:0] REG_DIST_PER_COUNT  = 2'd0;
  localparam logic [1:0] REG_ANGLE_PER_COUNT = 2'd1;
  localparam logic [1:0] REG_MIN_MOVE        = 2'd2;

  localparam logic [23:0] DIST_PER_COUNT_RST  = 24'd171299;
  localparam logic [29:0] ANGLE_PER_COUNT_RST = 30'd38774010;
  localparam logic [23:0] MIN_MOVE_RST        = 24'd168;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  function automatic logic [ANGLE_W-1:0] atan_val(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/ddo_mul.sv =====
// Registered signed multiplier for the position update partial products.
module ddo_mul (
  input  logic                                clk,
  input  logic signed [ddo_pkg::MUL_A_W-1:0]  a,
  input  logic signed [ddo_pkg::MUL_B_W-1:0]  b,
  output logic signed [ddo_pkg::MUL_P_W-1:0]  p
);

  logic signed [ddo_pkg::MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= ddo_pkg::MUL_P_W'(a) * ddo_pkg::MUL_P_W'(b);
  end

  assign p = p_r;

endmodule

// ===== sv/ddo_cordic.sv =====
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle in Q2.30.
module ddo_cordic #(
  parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [ddo_pkg::ANGLE_W-1:0]         angle,
  output ddo_pkg::cordic_stat_t               stat,
  output logic signed [ddo_pkg::TRIG_W-1:0]   cos_out,
  output logic signed [ddo_pkg::TRIG_W-1:0]   sin_out
);

  localparam int CW = $clog2(STEPS);

  logic signed [ddo_pkg::TRIG_W-1:0] x_r, y_r, z_r;
  logic signed [ddo_pkg::TRIG_W-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [ddo_pkg::TRIG_W-1:0] a_ext, z_fold, sx, sy, at;
  logic                              neg_r, neg_fold;
  logic [CW-1:0]                     cnt_r;
  logic                              busy_r, done_r;

  always_comb begin
    a_ext    = {angle[ddo_pkg::ANGLE_W-1], angle};
    z_fold   = a_ext;
    neg_fold = 1'b0;
    if (a_ext > ddo_pkg::QUARTER_TURN) begin
      z_fold   = a_ext - ddo_pkg::HALF_TURN;
      neg_fold = 1'b1;
    end else if (a_ext < -ddo_pkg::QUARTER_TURN) begin
      z_fold   = a_ext + ddo_pkg::HALF_TURN;
      neg_fold = 1'b1;
    end
    sx = x_r >>> cnt_r;
    sy = y_r >>> cnt_r;
    at = $signed({1'b0, ddo_pkg::atan_val(ddo_pkg::ATAN_IDX_W'(cnt_r))});
    if (!z_r[ddo_pkg::TRIG_W-1]) begin
      x_nxt = x_r - sy;
      y_nxt = y_r + sx;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + sy;
      y_nxt = y_r - sx;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= ddo_pkg::CORDIC_GAIN;
      y_r   <= '0;
      z_r   <= z_fold;
      neg_r <= neg_fold;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign cos_out   = neg_r ? -x_r : x_r;
  assign sin_out   = neg_r ? -y_r : y_r;

endmodule

// ===== sv/diff_drive_odometry.sv =====
// Differential-drive odometry top level: sequencer, pose state and stream ports.
// One item (a pair of cumulative wheel counts) gives one result (pose, heading,
// heading quaternion). A single CORDIC unit serves both the midpoint-heading
// rotation and the quaternion terms, so an item that moves the position runs
// two CORDIC rotations and an item that does not move it runs one, and the
// next item is not taken in until the result is in the output register. The
// position update runs its four partial products through one registered
// multiplier. A finished result waits in the output register while the next
// item is taken in; configuration writes are accepted only while no item is
// in progress and take effect on the next item.
module diff_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
  parameter int COUNT_BITS   = ddo_pkg::COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // count_left[31:0], count_right[63:32]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // x_pos, y_pos, heading, quat_z, quat_w
  output logic         out_tuser,  // moved
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [29:0]  cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PROD   = 4'd1;
  localparam logic [3:0] S_CHK    = 4'd2;
  localparam logic [3:0] S_ROT1   = 4'd3;
  localparam logic [3:0] S_MULA   = 4'd4;
  localparam logic [3:0] S_MULB   = 4'd5;
  localparam logic [3:0] S_HSTART = 4'd6;
  localparam logic [3:0] S_HROT   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_r, state_nxt;

  logic [23:0] dist_per_count_r;
  logic [29:0] angle_per_count_r;
  logic [23:0] min_move_r;

  logic [COUNT_BITS-1:0] prev_left_r, prev_right_r;
  logic signed [39:0]    x_acc_r, y_acc_r;
  logic [31:0]           heading_acc_r;

  logic signed [15:0] dl_r, dr_r, dl_c, dr_c;
  logic               moved_r;
  logic signed [39:0] ds_r;
  logic [31:0]        dth_lo_r, dth_half_r;
  logic signed [22:0] c_r, s_r;
  logic [1:0]         mcnt_r;
  logic signed [39:0] sx_r;

  logic signed [16:0] dsum, ddiff;
  logic signed [41:0] ds_prod, ds_adj;
  logic signed [47:0] dth_prod, dth_adj;
  logic [39:0]        ds_mag;
  logic               do_move;

  logic                                cstart;
  logic [ddo_pkg::ANGLE_W-1:0]         cangle;
  ddo_pkg::cordic_stat_t               cstat;
  logic signed [ddo_pkg::TRIG_W-1:0]   ccos, csin, ccos_sh, csin_sh;

  logic signed [ddo_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [ddo_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [ddo_pkg::MUL_P_W-1:0]  mul_p;
  logic signed [ddo_pkg::MUL_P_W-1:0]  mul_lo_sh;

  logic                out_tvalid_r;
  logic [127:0]        out_tdata_r;
  logic                out_tuser_r;
  logic                out_free;

  function automatic logic signed [15:0] clamp_delta(input logic [COUNT_BITS-1:0] d);
    logic signed [COUNT_BITS-1:0] sd;
    logic signed [COUNT_BITS-1:0] lim;
    sd  = $signed(d);
    lim = $signed(COUNT_BITS'(ddo_pkg::DELTA_MAX));
    if (sd > lim) begin
      return $signed(ddo_pkg::DELTA_MAX);
    end else if (sd < -lim) begin
      return -$signed(ddo_pkg::DELTA_MAX);
    end
    return sd[15:0];
  endfunction

  function automatic logic [15:0] to_q15(input logic signed [ddo_pkg::TRIG_W-1:0] v);
    logic signed [ddo_pkg::TRIG_W:0] t;
    logic signed [ddo_pkg::TRIG_W:0] r;
    t = {v[ddo_pkg::TRIG_W-1], v} + 34'sd16384;
    r = t >>> 15;
    if (r > 34'sd32767) begin
      return 16'h7fff;
    end else if (r < -34'sd32768) begin
      return 16'h8000;
    end
    return r[15:0];
  endfunction

  ddo_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cstart),
    .angle   (cangle),
    .stat    (cstat),
    .cos_out (ccos),
    .sin_out (csin)
  );

  ddo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_free   = !out_tvalid_r || out_tready;

  always_comb begin
    dl_c     = clamp_delta(in_tdata[COUNT_BITS-1:0] - prev_left_r);
    dr_c     = clamp_delta(in_tdata[32 +: COUNT_BITS] - prev_right_r);
    dsum     = {dl_r[15], dl_r} + {dr_r[15], dr_r};
    ddiff    = {dr_r[15], dr_r} - {dl_r[15], dl_r};
    ds_prod  = 42'(dsum) * $signed({18'b0, dist_per_count_r});
    ds_adj   = ds_prod + 42'(ds_prod[41]);
    dth_prod = 48'(ddiff) * $signed({18'b0, angle_per_count_r});
    dth_adj  = dth_prod + 48'(dth_prod[47]);
    ds_mag   = ds_r[39] ? 40'(-ds_r) : 40'(ds_r);
    do_move  = moved_r && (ds_mag > {16'b0, min_move_r});
    ccos_sh  = ccos >>> 10;
    csin_sh  = csin >>> 10;
    mul_a    = mcnt_r[0] ? ddo_pkg::MUL_A_W'($signed(ds_r[39:20]))
                         : $signed({1'b0, ds_r[19:0]});
    mul_b    = mcnt_r[1] ? s_r : c_r;
    mul_lo_sh = mul_p >>> 20;
    cstart   = ((state_r == S_CHK) && do_move) || (state_r == S_HSTART);
    cangle   = (state_r == S_CHK) ? heading_acc_r + dth_half_r
                                  : {heading_acc_r[31], heading_acc_r[31:1]};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_PROD;
      S_PROD:   state_nxt = S_CHK;
      S_CHK:    state_nxt = do_move ? S_ROT1 : S_HSTART;
      S_ROT1:   if (cstat.done) state_nxt = S_MULA;
      S_MULA:   state_nxt = S_MULB;
      S_MULB:   state_nxt = (mcnt_r == 2'd3) ? S_HSTART : S_MULA;
      S_HSTART: state_nxt = S_HROT;
      S_HROT:   if (cstat.done) state_nxt = S_OUT;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      dist_per_count_r  <= ddo_pkg::DIST_PER_COUNT_RST;
      angle_per_count_r <= ddo_pkg::ANGLE_PER_COUNT_RST;
      min_move_r        <= ddo_pkg::MIN_MOVE_RST;
      prev_left_r       <= '0;
      prev_right_r      <= '0;
      x_acc_r           <= '0;
      y_acc_r           <= '0;
      heading_acc_r     <= '0;
      mcnt_r            <= '0;
      out_tvalid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ddo_pkg::REG_DIST_PER_COUNT:  dist_per_count_r  <= cfg_data[23:0];
          ddo_pkg::REG_ANGLE_PER_COUNT: angle_per_count_r <= cfg_data;
          ddo_pkg::REG_MIN_MOVE:        min_move_r        <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        prev_left_r  <= in_tdata[COUNT_BITS-1:0];
        prev_right_r <= in_tdata[32 +: COUNT_BITS];
      end
      if ((state_r == S_CHK) && moved_r) begin
        heading_acc_r <= heading_acc_r + dth_lo_r;
      end
      if (state_r == S_CHK) begin
        mcnt_r <= '0;
      end else if (state_r == S_MULB) begin
        mcnt_r <= mcnt_r + 1'b1;
        if (mcnt_r[0]) begin
          if (mcnt_r[1]) begin
            y_acc_r <= y_acc_r + sx_r + mul_p[39:0];
          end else begin
            x_acc_r <= x_acc_r + sx_r + mul_p[39:0];
          end
        end
      end
      if ((state_r == S_OUT) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      dl_r    <= dl_c;
      dr_r    <= dr_c;
      moved_r <= (dl_c != 16'sd0) || (dr_c != 16'sd0);
    end
    if (state_r == S_PROD) begin
      ds_r       <= ds_adj[40:1];
      dth_lo_r   <= dth_prod[31:0];
      dth_half_r <= dth_adj[32:1];
    end
    if ((state_r == S_ROT1) && cstat.done) begin
      c_r <= ccos_sh[22:0];
      s_r <= csin_sh[22:0];
    end
    if ((state_r == S_MULB) && !mcnt_r[0]) begin
      sx_r <= mul_lo_sh[39:0];
    end
    if ((state_r == S_OUT) && out_free) begin
      out_tdata_r <= {to_q15(ccos), to_q15(csin), heading_acc_r,
                      y_acc_r[39:8], x_acc_r[39:8]};
      out_tuser_r <= moved_r;
    end
  end

  a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !cstat.busy)
    else $error("rotation unit busy while idle");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    cstat.done |-> (state_r == S_ROT1 || state_r == S_HROT))
    else $error("rotation done outside a wait state");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_PROD))
    else $error("accepted item did not start");

  a_x_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_MULB) |=> $stable(x_acc_r))
    else $error("x accumulator changed outside update");

endmodule

// ===== bench/ddo_pose_checker.sv =====
// Pose checker: predicts each odometry result from accepted count pairs and compares it.
`timescale 1ns / 100ps

module ddo_pose_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [63:0]  in_tdata,   // count_left[31:0], count_right[63:32]
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,  // x_pos, y_pos, heading, quat_z, quat_w
  input  logic         out_tuser,  // moved
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [29:0]  cfg_data,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic [31:0] x_pos;
    logic [31:0] y_pos;
    logic [31:0] heading;
    logic [15:0] quat_z;
    logic [15:0] quat_w;
    logic        moved;
  } pose_t;

  typedef struct packed {
    logic [63:0] c;
    logic [63:0] s;
  } trig_t;

  longint arc_tab [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1
  };

  logic [23:0] dist_gain;
  logic [29:0] turn_gain;
  logic [23:0] move_floor;
  logic [31:0] last_left;
  logic [31:0] last_right;
  logic [31:0] yaw;
  logic [39:0] pos_x;
  logic [39:0] pos_y;

  pose_t pose_q [$];
  int    result_no;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic longint wheel_step(input logic [31:0] cur, input logic [31:0] prev);
    logic [31:0] d;
    longint      sd;
    longint      lim;
    d   = cur - prev;
    sd  = longint'($signed(d));
    lim = longint'(ddo_pkg::DELTA_MAX);
    if (sd > lim) sd = lim;
    if (sd < -lim) sd = -lim;
    return sd;
  endfunction

  // cos and sin of a binary angle, Q2.30
  function automatic trig_t rotate(input logic [31:0] ang);
    longint z;
    longint xr;
    longint yr;
    longint t;
    logic   flip;
    int     i;
    trig_t  r;
    z    = longint'($signed(ang));
    xr   = longint'(ddo_pkg::CORDIC_GAIN);
    yr   = 0;
    flip = 1'b0;
    if (z > longint'(ddo_pkg::QUARTER_TURN) || z < -longint'(ddo_pkg::QUARTER_TURN)) begin
      z    = (z > 0) ? z - longint'(ddo_pkg::HALF_TURN) : z + longint'(ddo_pkg::HALF_TURN);
      flip = 1'b1;
    end
    for (i = 0; i < ddo_pkg::CORDIC_STEPS_DEF; i++) begin
      if (z >= 0) begin
        t  = xr - (yr >>> i);
        yr = yr + (xr >>> i);
        z  = z - arc_tab[i];
      end else begin
        t  = xr + (yr >>> i);
        yr = yr - (xr >>> i);
        z  = z + arc_tab[i];
      end
      xr = t;
    end
    r.c = flip ? -xr : xr;
    r.s = flip ? -yr : yr;
    return r;
  endfunction

  function automatic logic [15:0] to_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic pose_t advance_pose(input logic [31:0] cl, input logic [31:0] cr);
    longint      dl;
    longint      dr;
    longint      ds;
    longint      dth;
    longint      mag;
    longint      c;
    longint      s;
    longint      sum;
    logic [31:0] half_turn;
    logic [31:0] dth_lo;
    logic [31:0] mid;
    trig_t       tr;
    pose_t       p;
    dl         = wheel_step(cl, last_left);
    dr         = wheel_step(cr, last_right);
    last_left  = cl;
    last_right = cr;
    p.moved    = (dl != 0) || (dr != 0);
    if (p.moved) begin
      ds  = ((dl + dr) * longint'(dist_gain)) / 2;
      dth = (dr - dl) * longint'(turn_gain);
      mag = (ds < 0) ? -ds : ds;
      if (mag > longint'(move_floor)) begin
        half_turn = 32'(dth / 2);
        mid       = yaw + half_turn;
        tr        = rotate(mid);
        c         = $signed(tr.c) >>> 10;
        s         = $signed(tr.s) >>> 10;
        sum       = longint'($signed(pos_x)) + ((ds * c) >>> 20);
        pos_x     = sum[39:0];
        sum       = longint'($signed(pos_y)) + ((ds * s) >>> 20);
        pos_y     = sum[39:0];
      end
      dth_lo = 32'(dth);
      yaw    = yaw + dth_lo;
    end
    sum       = longint'($signed(yaw)) >>> 1;
    tr        = rotate(sum[31:0]);
    sum       = longint'($signed(pos_x)) >>> 8;
    p.x_pos   = sum[31:0];
    sum       = longint'($signed(pos_y)) >>> 8;
    p.y_pos   = sum[31:0];
    p.heading = yaw;
    p.quat_z  = to_q15($signed(tr.s));
    p.quat_w  = to_q15($signed(tr.c));
    return p;
  endfunction

  task automatic check_field(input string nm, input longint want, input longint got);
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("result %0d %s: expected %0d, got %0d", result_no, nm, want, got);
    end
  endtask

  always @(posedge clk) begin
    pose_t want;
    if (!rst_n) begin
      dist_gain  = ddo_pkg::DIST_PER_COUNT_RST;
      turn_gain  = ddo_pkg::ANGLE_PER_COUNT_RST;
      move_floor = ddo_pkg::MIN_MOVE_RST;
      last_left  = '0;
      last_right = '0;
      yaw        = '0;
      pos_x      = '0;
      pos_y      = '0;
      result_no  = 0;
      pose_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ddo_pkg::REG_DIST_PER_COUNT:  dist_gain  = cfg_data[23:0];
          ddo_pkg::REG_ANGLE_PER_COUNT: turn_gain  = cfg_data;
          ddo_pkg::REG_MIN_MOVE:        move_floor = cfg_data[23:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (pose_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result %0d arrived with no item pending", result_no);
        end else begin
          want = pose_q.pop_front();
          check_field("x_pos", longint'($signed(want.x_pos)),
                      longint'($signed(out_tdata[31:0])));
          check_field("y_pos", longint'($signed(want.y_pos)),
                      longint'($signed(out_tdata[63:32])));
          check_field("heading", longint'($signed(want.heading)),
                      longint'($signed(out_tdata[95:64])));
          check_field("quat_z", longint'($signed(want.quat_z)),
                      longint'($signed(out_tdata[111:96])));
          check_field("quat_w", longint'($signed(want.quat_w)),
                      longint'($signed(out_tdata[127:112])));
          check_field("moved", longint'(want.moved), longint'(out_tuser));
        end
        result_no++;
      end
      if (in_tvalid && in_tready)
        pose_q.push_back(advance_pose(in_tdata[31:0], in_tdata[63:32]));
    end
    pending = pose_q.size();
  end

endmodule

// ===== bench/tb_diff_drive_odometry.sv =====
// Testbench top for diff_drive_odometry: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 100ps

module tb_diff_drive_odometry;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE    = 2 * ddo_pkg::CORDIC_STEPS_DEF + 25;
  localparam int MAX_CYCLES = 800000;
  localparam int PER_PHASE = 300;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [29:0]  cfg_data;

  int          errors;
  int          pending;
  int          cycles = 0;
  logic        calm = 1'b0;
  logic [31:0] pcl = '0;
  logic [31:0] pcr = '0;
  int          sent;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  diff_drive_odometry dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ddo_pose_checker u_pose_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending)
  );

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int srand(input int m);
    return int'($urandom_range(2 * m)) - m;
  endfunction

  // hold valid across back-to-back items, drop it only for a gap
  task automatic drive_counts(input logic [31:0] l, input logic [31:0] r);
    if (!calm) begin
      while ($urandom_range(99) < 21) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r, l};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    pcl = l;
    pcr = r;
    sent++;
  endtask

  task automatic nudge(input int dl, input int dr);
    drive_counts(pcl + dl, pcr + dr);
  endtask

  task automatic random_item();
    int mode;
    int base;
    mode = $urandom_range(99);
    if (mode < 8) begin
      nudge(0, 0);
    end else if (mode < 50) begin
      base = srand(300);
      nudge(base, base + srand(40));
    end else if (mode < 70) begin
      nudge(srand(4000), srand(4000));
    end else if (mode < 80) begin
      if ($urandom_range(1)) nudge(srand(2000), 0);
      else nudge(0, srand(2000));
    end else if (mode < 88) begin
      nudge(($urandom_range(1) ? 1 : -1) * int'($urandom_range(32000, 33000)),
            ($urandom_range(1) ? 1 : -1) * int'($urandom_range(32000, 33000)));
    end else begin
      drive_counts($urandom, $urandom);
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [29:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    sent      = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: begin
            cfg_write(ddo_pkg::REG_DIST_PER_COUNT, 30'h00FF_FFFF);
            cfg_write(ddo_pkg::REG_ANGLE_PER_COUNT, 30'h3FFF_FFFF);
            cfg_write(ddo_pkg::REG_MIN_MOVE, 30'h0);
          end
          2: begin
            cfg_write(ddo_pkg::REG_DIST_PER_COUNT, 30'h0);
            cfg_write(ddo_pkg::REG_ANGLE_PER_COUNT, 30'h0);
            cfg_write(ddo_pkg::REG_MIN_MOVE, 30'h00FF_FFFF);
            cfg_write(REG_UNUSED, 30'($urandom));
          end
          3: begin
            cfg_write(ddo_pkg::REG_DIST_PER_COUNT, 30'($urandom_range(0, 24'hFF_FFFF)));
            cfg_write(ddo_pkg::REG_ANGLE_PER_COUNT, 30'($urandom));
            cfg_write(ddo_pkg::REG_MIN_MOVE, 30'($urandom_range(0, 4000000)));
          end
          4: begin
            cfg_write(ddo_pkg::REG_DIST_PER_COUNT, 30'($urandom_range(0, 400000)));
            cfg_write(ddo_pkg::REG_ANGLE_PER_COUNT, 30'($urandom));
            cfg_write(ddo_pkg::REG_MIN_MOVE, 30'($urandom));
          end
          default: begin
            cfg_write(ddo_pkg::REG_DIST_PER_COUNT, {6'h2A, ddo_pkg::DIST_PER_COUNT_RST});
            cfg_write(ddo_pkg::REG_ANGLE_PER_COUNT, ddo_pkg::ANGLE_PER_COUNT_RST);
            cfg_write(ddo_pkg::REG_MIN_MOVE, {6'h3F, 24'd85649});
          end
        endcase
        cfg_valid <= 1'b0;
        @(negedge clk);
      end
      calm = (ph == 3);
      sent = 0;
      if (ph == 0) begin
        drive_counts(32'h0, 32'h0);
        nudge(100, 100);
        nudge(0, 0);
        nudge(50, 150);
        nudge(-1, 1);
        nudge(1, -1);
        drive_counts(32'hFFFF_FF00, pcr);
        nudge(32767, 32767);
        nudge(-32767, -32767);
        nudge(40000, -40000);
        drive_counts(pcl + 32'h7FFF_FFFF, pcr + 32'h8000_0000);
        drive_counts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drive_counts(32'h0, 32'h0);
        nudge(1, 0);
        nudge(0, 1);
        repeat (6) nudge(-32767, 32767);
      end else if (ph == 5) begin
        // distance equal to the threshold stays put, one count more moves
        nudge(1, 0);
        nudge(2, 0);
      end
      while (sent < PER_PHASE) random_item();
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
